FILE: sv/assert_macros.svh
// Assertion helpers for the relay block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define QSW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// same-cycle implication
`define QSW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: sv/qsw_pkg.sv
package qsw_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W     = 128;

   localparam int RF_DEPTH    = 4;
   localparam int RF_PTR_W    = $clog2(RF_DEPTH);
   localparam int RF_CNT_W    = $clog2(RF_DEPTH + 1);

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ATTEMPTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF      = 2'd2;

   localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd3;
   localparam logic [15:0] RST_ACK_TIMEOUT  = 16'd1500;
   localparam logic [15:0] RST_BACKOFF      = 16'd500;

   localparam logic [3:0]  ATTEMPT_FIRST = 4'd1;
   localparam logic [3:0]  ATTEMPT_TOP   = 4'hF;
   localparam logic [15:0] TIMER_TOP     = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEND,
      PH_LISTEN,
      PH_BACKOFF
   } phase_type;

   typedef enum logic [1:0] {
      CMD_READING,
      CMD_TICK,
      CMD_FRAME,
      CMD_OUTCOME
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_SEND,
      EV_QUEUED,
      EV_FULL,
      EV_LENGTH,
      EV_ACKED,
      EV_BACKOFF,
      EV_FAILED
   } ev_type;

   typedef struct packed {
      logic [31:0] uid;
      logic [31:0] seq;
      logic [63:0] body;
   } entry_type;

   typedef struct packed {
      ev_type      ev;
      entry_type   entry;
      logic [3:0]  attempt;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       v0;
      logic       v1;
      result_type r0;
      result_type r1;
   } push_type;

   typedef struct packed {
      logic [3:0]  max_attempts;
      logic [15:0] ack_timeout;
      logic [15:0] backoff;
   } cfg_type;

   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] count;
      logic [3:0]       attempt;
   } stat_type;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
      if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   function automatic result_type make_res(input ev_type ev, input entry_type e,
                                           input logic [3:0] att);
      result_type r;
      r.ev      = ev;
      r.entry   = e;
      r.attempt = att;
      r.last    = 1'b1;
      return r;
   endfunction

endpackage

FILE: sv/qsw_ram.sv
module qsw_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/qsw_ctrl.sv
module qsw_ctrl
   import qsw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      go,
   input  cmd_type   in_cmd,
   input  logic      in_ok,
   input  entry_type in_entry,
   input  cfg_type   cfg,
   output push_type  push,
   output stat_type  stat
);

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   phase_type        phase_ff, phase_in;
   logic [3:0]       attempt_ff, attempt_in;
   logic [15:0]      timer_ff, timer_in;
   entry_type        head_data_ff, head_data_in;
   logic             fwd_ff, fwd_in;
   entry_type        fwd_data_ff;

   logic             wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type        nxt_data;
   logic             can_retry;
   logic [15:0]      timer_inc;
   logic             fin;
   ev_type           fin_ev;

   qsw_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (in_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // entry behind the head; a write to it last cycle is forwarded
   assign nxt_data  = fwd_ff ? fwd_data_ff : entry_type'(rd_raw);
   assign can_retry = (attempt_ff < cfg.max_attempts) && (attempt_ff != ATTEMPT_TOP);
   assign timer_inc = (timer_ff == TIMER_TOP) ? timer_ff : timer_ff + 16'd1;
   assign rd_addr   = wrap_next(head_in);
   assign fwd_in    = wr_en && (tail_ff == rd_addr);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      attempt_in   = attempt_ff;
      timer_in     = timer_ff;
      head_data_in = head_data_ff;
      wr_en        = 1'b0;
      fin          = 1'b0;
      fin_ev       = EV_NONE;
      push.v0      = 1'b0;
      push.v1      = 1'b0;
      push.r0      = make_res(EV_NONE, in_entry, attempt_ff);
      push.r1      = make_res(EV_NONE, head_data_ff, attempt_ff);
      if (go) begin
         unique case (in_cmd)
            CMD_READING: begin
               push.v0 = 1'b1;
               if (!in_ok) begin
                  push.r0 = make_res(EV_LENGTH, in_entry, attempt_ff);
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  push.r0 = make_res(EV_FULL, in_entry, attempt_ff);
               end else begin
                  push.r0  = make_res(EV_QUEUED, in_entry, attempt_ff);
                  wr_en    = 1'b1;
                  tail_in  = wrap_next(tail_ff);
                  count_in = count_ff + 1'b1;
                  if (phase_ff == PH_IDLE) begin
                     phase_in     = PH_SEND;
                     attempt_in   = ATTEMPT_FIRST;
                     timer_in     = '0;
                     head_data_in = in_entry;
                     push.v1      = 1'b1;
                     push.r1      = make_res(EV_SEND, in_entry, ATTEMPT_FIRST);
                  end
               end
            end
            CMD_TICK: begin
               if (phase_ff == PH_LISTEN) begin
                  if (timer_inc >= cfg.ack_timeout) begin
                     timer_in = '0;
                     if (can_retry) begin
                        phase_in = PH_BACKOFF;
                        push.v0  = 1'b1;
                        push.r0  = make_res(EV_BACKOFF, head_data_ff, attempt_ff);
                        if (cfg.backoff == '0) begin
                           phase_in   = PH_SEND;
                           attempt_in = attempt_ff + 1'b1;
                           push.v1    = 1'b1;
                           push.r1    = make_res(EV_SEND, head_data_ff,
                                                 attempt_ff + 1'b1);
                        end
                     end else begin
                        fin    = 1'b1;
                        fin_ev = EV_FAILED;
                     end
                  end else begin
                     timer_in = timer_inc;
                  end
               end else if (phase_ff == PH_BACKOFF) begin
                  if (timer_inc >= cfg.backoff) begin
                     timer_in   = '0;
                     phase_in   = PH_SEND;
                     attempt_in = attempt_ff + 1'b1;
                     push.v0    = 1'b1;
                     push.r0    = make_res(EV_SEND, head_data_ff, attempt_ff + 1'b1);
                  end else begin
                     timer_in = timer_inc;
                  end
               end
            end
            CMD_FRAME: begin
               if (phase_ff == PH_LISTEN && in_ok && in_entry.uid == head_data_ff.uid
                   && in_entry.seq == head_data_ff.seq) begin
                  fin    = 1'b1;
                  fin_ev = EV_ACKED;
               end
            end
            CMD_OUTCOME: begin
               if (phase_ff == PH_SEND) begin
                  if (in_ok) begin
                     phase_in = PH_LISTEN;
                     timer_in = '0;
                  end else if (can_retry) begin
                     timer_in   = '0;
                     attempt_in = attempt_ff + 1'b1;
                     push.v0    = 1'b1;
                     push.r0    = make_res(EV_SEND, head_data_ff, attempt_ff + 1'b1);
                  end else begin
                     fin    = 1'b1;
                     fin_ev = EV_FAILED;
                  end
               end
            end
            default: begin
            end
         endcase
         if (fin) begin
            push.v0  = 1'b1;
            push.r0  = make_res(fin_ev, head_data_ff, attempt_ff);
            head_in  = wrap_next(head_ff);
            count_in = count_ff - 1'b1;
            timer_in = '0;
            if (count_ff > CNT_W'(1)) begin
               phase_in     = PH_SEND;
               attempt_in   = ATTEMPT_FIRST;
               head_data_in = nxt_data;
               push.v1      = 1'b1;
               push.r1      = make_res(EV_SEND, nxt_data, ATTEMPT_FIRST);
            end else begin
               phase_in   = PH_IDLE;
               attempt_in = '0;
            end
         end
         push.r0.last = !push.v1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         phase_ff   <= PH_IDLE;
         attempt_ff <= '0;
         timer_ff   <= '0;
         fwd_ff     <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         phase_ff   <= phase_in;
         attempt_ff <= attempt_in;
         timer_ff   <= timer_in;
         fwd_ff     <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      head_data_ff <= head_data_in;
      fwd_data_ff  <= in_entry;
   end

   assign stat.phase   = phase_ff;
   assign stat.count   = count_ff;
   assign stat.attempt = attempt_ff;

endmodule

FILE: sv/qsw_rsp_fifo.sv
module qsw_rsp_fifo
   import qsw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room2,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   result_type          slot_ff [RF_DEPTH];
   logic [RF_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [RF_CNT_W-1:0] fill_ff, fill_in;
   logic [RF_PTR_W-1:0] wr_next;
   logic                pop;

   assign wr_next   = wr_ff + 1'b1;
   assign out_valid = (fill_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_res   = slot_ff[rd_ff];
   assign room2     = (fill_ff <= RF_CNT_W'(RF_DEPTH - 2));

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push.v0) begin
         wr_in   = wr_next;
         fill_in = fill_in + 1'b1;
      end
      if (push.v1) begin
         wr_in   = wr_next + 1'b1;
         fill_in = fill_in + 1'b1;
      end
      if (pop) begin
         rd_in   = rd_ff + 1'b1;
         fill_in = fill_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         slot_ff[wr_ff] <= push.r0;
      end
      if (push.v1) begin
         slot_ff[wr_next] <= push.r1;
      end
   end

endmodule

FILE: sv/queued_stop_and_wait_relay_unit.sv
// Stop-and-wait relay: readings are queued in a 16-entry memory and sent one at a
// time, each retried until acked or out of attempts. A word is taken on every cycle
// while the 4-deep result queue has room for two results; a word yields up to two
// results and the result side drains one per cycle while rsp_tready is high, so the
// rate is one word per cycle when each causes at most one result; two-result words
// are held off by the room check. Queue state is read ahead from memory, forwarding
// a same-entry write, so no word waits on it. No clearing pass follows reset.
`include "assert_macros.svh"

module queued_stop_and_wait_relay_unit
   import qsw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [127:0]          req_tdata,  // uid[31:0], seq[63:32], body[127:64]
   input  logic [2:0]            req_tuser,  // cmd[1:0], frame_ok[2]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [135:0]          rsp_tdata,  // out_uid[31:0], out_seq[63:32],
                                             // out_body[127:64], attempt[131:128]
   output logic [2:0]            rsp_tuser,  // event_res[2:0]
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   push_type   push;
   stat_type   stat;
   result_type res;
   entry_type  in_entry;
   logic       go;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_ATTEMPTS: cfg_in.max_attempts = csr_data[3:0];
            CSR_ACK_TIMEOUT:  cfg_in.ack_timeout  = csr_data;
            CSR_BACKOFF:      cfg_in.backoff      = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts <= RST_MAX_ATTEMPTS;
         cfg_ff.ack_timeout  <= RST_ACK_TIMEOUT;
         cfg_ff.backoff      <= RST_BACKOFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign go            = req_tvalid && req_tready;
   assign in_entry.uid  = req_tdata[31:0];
   assign in_entry.seq  = req_tdata[63:32];
   assign in_entry.body = req_tdata[127:64];

   qsw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .in_cmd   (cmd_type'(req_tuser[1:0])),
      .in_ok    (req_tuser[2]),
      .in_entry (in_entry),
      .cfg      (cfg_ff),
      .push     (push),
      .stat     (stat)
   );

   qsw_rsp_fifo u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room2     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res)
   );

   assign rsp_tuser = res.ev;
   assign rsp_tlast = res.last;
   assign rsp_tdata = {4'd0, res.attempt, res.entry.body, res.entry.seq, res.entry.uid};

   `QSW_ASSERT_IMPL(a_idle_clean, clock, reset, stat.phase == PH_IDLE, stat.count == '0 && stat.attempt == '0, "idle with queued reading or attempt")
   `QSW_ASSERT_IMPL(a_busy_head, clock, reset, stat.phase != PH_IDLE, stat.count != '0 && stat.attempt != '0, "busy without a head reading")
   `QSW_ASSERT(a_count_bound, clock, reset, stat.count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

FILE: test/tb_queued_stop_and_wait_relay_unit.sv
module tb_queued_stop_and_wait_relay_unit;
   import qsw_pkg::*;

   localparam longint CYCLE_LIMIT = 2000000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [127:0]          req_tdata;  // uid[31:0], seq[63:32], body[127:64]
   logic [2:0]            req_tuser;  // cmd[1:0], frame_ok[2]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [135:0]          rsp_tdata;  // out_uid[31:0], out_seq[63:32],
                                      // out_body[127:64], attempt[131:128]
   logic [2:0]            rsp_tuser;  // event_res[2:0]
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   queued_stop_and_wait_relay_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // relay state as predicted
   entry_type        relay_store [QUEUE_DEPTH];
   logic [IDX_W-1:0] relay_head;
   logic [IDX_W-1:0] relay_tail;
   logic [CNT_W-1:0] relay_count;
   phase_type        relay_phase;
   logic [3:0]       relay_attempt;
   logic [15:0]      relay_timer;
   logic [3:0]       cfg_max_attempts;
   logic [15:0]      cfg_ack_timeout;
   logic [15:0]      cfg_backoff;

   result_type step_buf [2];
   int         step_n;
   result_type pending_results [$];

   int     send_idle_pct = 0;
   int     rsp_idle_pct = 0;
   int     hold_left = 0;
   int     error_count = 0;
   longint cycle_count = 0;

   function automatic void note_result(ev_type ev, entry_type e);
      result_type r;
      r.ev      = ev;
      r.entry   = e;
      r.attempt = relay_attempt;
      r.last    = 1'b0;
      step_buf[step_n] = r;
      step_n++;
   endfunction

   function automatic void open_attempt();
      relay_phase = PH_SEND;
      relay_timer = '0;
      note_result(EV_SEND, relay_store[relay_head]);
   endfunction

   function automatic void open_next();
      if (relay_count > 0) begin
         relay_attempt = 4'd1;
         open_attempt();
      end else begin
         relay_phase   = PH_IDLE;
         relay_attempt = '0;
         relay_timer   = '0;
      end
   endfunction

   function automatic void close_head(ev_type ev);
      note_result(ev, relay_store[relay_head]);
      relay_head    = relay_head + 1'b1;  // depth is a power of two
      relay_count   = relay_count - 1'b1;
      relay_attempt = '0;
      open_next();
   endfunction

   function automatic bit retry_left();
      return relay_attempt < cfg_max_attempts && relay_attempt != 4'hF;
   endfunction

   function automatic void predict_word(cmd_type cmd, logic ok, logic [31:0] uid,
                                        logic [31:0] seq, logic [63:0] body);
      entry_type w;
      w.uid  = uid;
      w.seq  = seq;
      w.body = body;
      step_n = 0;
      case (cmd)
         CMD_READING: begin
            if (!ok) begin
               note_result(EV_LENGTH, w);
            end else if (relay_count >= QUEUE_DEPTH) begin
               note_result(EV_FULL, w);
            end else begin
               relay_store[relay_tail] = w;
               relay_tail  = relay_tail + 1'b1;
               relay_count = relay_count + 1'b1;
               note_result(EV_QUEUED, w);
               if (relay_phase == PH_IDLE) open_next();
            end
         end
         CMD_TICK: begin
            if (relay_phase == PH_LISTEN || relay_phase == PH_BACKOFF) begin
               if (relay_timer != 16'hFFFF) relay_timer = relay_timer + 1'b1;
               if (relay_phase == PH_LISTEN && relay_timer >= cfg_ack_timeout) begin
                  relay_timer = '0;
                  if (retry_left()) begin
                     relay_phase = PH_BACKOFF;
                     note_result(EV_BACKOFF, relay_store[relay_head]);
                     if (cfg_backoff == 0) begin
                        relay_attempt = relay_attempt + 1'b1;
                        open_attempt();
                     end
                  end else begin
                     close_head(EV_FAILED);
                  end
               end else if (relay_phase == PH_BACKOFF && relay_timer >= cfg_backoff) begin
                  relay_attempt = relay_attempt + 1'b1;
                  open_attempt();
               end
            end
         end
         CMD_FRAME: begin
            if (relay_phase == PH_LISTEN && ok && uid == relay_store[relay_head].uid &&
                seq == relay_store[relay_head].seq) begin
               close_head(EV_ACKED);
            end
         end
         default: begin
            if (relay_phase == PH_SEND) begin
               if (ok) begin
                  relay_phase = PH_LISTEN;
                  relay_timer = '0;
               end else if (retry_left()) begin
                  relay_attempt = relay_attempt + 1'b1;
                  open_attempt();
               end else begin
                  close_head(EV_FAILED);
               end
            end
         end
      endcase
      if (step_n > 0) step_buf[step_n-1].last = 1'b1;
      for (int i = 0; i < step_n; i++) pending_results.push_back(step_buf[i]);
   endfunction

   function automatic logic [31:0] pick32();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom();
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ev         = ev_type'(rsp_tuser);
         got.entry.uid  = rsp_tdata[31:0];
         got.entry.seq  = rsp_tdata[63:32];
         got.entry.body = rsp_tdata[127:64];
         got.attempt    = rsp_tdata[131:128];
         got.last       = rsp_tlast;
         if (pending_results.size() == 0) begin
            if (error_count < 50)
               $display("%0t unexpected word: ev=%0d uid=%h seq=%h body=%h att=%0d last=%0b",
                        $time, got.ev, got.entry.uid, got.entry.seq, got.entry.body,
                        got.attempt, got.last);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               if (error_count < 50) begin
                  $display("%0t mismatch expected: ev=%0d uid=%h seq=%h body=%h att=%0d last=%0b",
                           $time, want.ev, want.entry.uid, want.entry.seq, want.entry.body,
                           want.attempt, want.last);
                  $display("%0t mismatch actual:   ev=%0d uid=%h seq=%h body=%h att=%0d last=%0b",
                           $time, got.ev, got.entry.uid, got.entry.seq, got.entry.body,
                           got.attempt, got.last);
               end
               error_count++;
            end
         end
      end
   end

   task automatic send_word(cmd_type cmd, logic ok, logic [31:0] uid, logic [31:0] seq,
                            logic [63:0] body);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {body, seq, uid};
      req_tuser  = {ok, cmd};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      predict_word(cmd, ok, uid, seq, body);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // words that cause no result may still be in flight
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         CSR_MAX_ATTEMPTS: cfg_max_attempts = value[3:0];
         CSR_ACK_TIMEOUT:  cfg_ack_timeout  = value;
         CSR_BACKOFF:      cfg_backoff      = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_timers(logic [3:0] attempts, logic [15:0] timeout, logic [15:0] pause);
      wait_quiet();
      write_csr(CSR_MAX_ATTEMPTS, {12'd0, attempts});
      write_csr(CSR_ACK_TIMEOUT, timeout);
      write_csr(CSR_BACKOFF, pause);
   endtask

   task automatic test_length_drop();
      send_word(CMD_READING, 1'b0, 32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_ignored_when_idle();
      send_word(CMD_TICK, 1'b1, 32'h1234_5678, 32'h9, 64'h0);
      send_word(CMD_FRAME, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_OUTCOME, 1'b1, 32'h0, 32'h0, 64'h0);
   endtask

   task automatic test_ack_path();
      send_word(CMD_READING, 1'b1, 32'hFFFF_FFFF, 32'h0, 64'h0);
      send_word(CMD_FRAME, 1'b1, 32'hFFFF_FFFF, 32'h0, 64'h0);
      send_word(CMD_TICK, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_OUTCOME, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_FRAME, 1'b0, 32'hFFFF_FFFF, 32'h0, 64'h0);
      send_word(CMD_FRAME, 1'b1, 32'hFFFF_FFFF, 32'h1, 64'h0);
      send_word(CMD_FRAME, 1'b1, 32'hFFFF_FFFE, 32'h0, 64'h0);
      send_word(CMD_FRAME, 1'b1, 32'hFFFF_FFFF, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0);
   endtask

   task automatic test_send_failures();
      send_word(CMD_READING, 1'b1, 32'h8000_0001, 32'h7FFF_FFFF, 64'h8000_0000_0000_0001);
      repeat (3) send_word(CMD_OUTCOME, 1'b0, 32'h0, 32'h0, 64'h0);
   endtask

   task automatic test_zero_timers();
      set_timers(4'd2, 16'd0, 16'd0);
      send_word(CMD_READING, 1'b1, 32'h0000_0042, 32'h0000_0007, 64'h1);
      send_word(CMD_OUTCOME, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_TICK, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_OUTCOME, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_TICK, 1'b1, 32'h0, 32'h0, 64'h0);
   endtask

   task automatic test_zero_attempts();
      set_timers(4'd0, 16'd1, 16'd1);
      send_word(CMD_READING, 1'b1, 32'h5555_AAAA, 32'hAAAA_5555, 64'h0);
      send_word(CMD_OUTCOME, 1'b0, 32'h0, 32'h0, 64'h0);
   endtask

   task automatic test_longest_timers();
      set_timers(4'd2, 16'hFFFF, 16'hFFFF);
      send_word(CMD_READING, 1'b1, 32'h0BAD_CAFE, 32'h0000_FFFF, 64'h0123_4567_89AB_CDEF);
      send_word(CMD_OUTCOME, 1'b1, 32'h0, 32'h0, 64'h0);
      repeat (20) send_word(CMD_TICK, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_OUTCOME, 1'b1, 32'h0, 32'h0, 64'h0);
      send_word(CMD_FRAME, 1'b1, 32'h0BAD_CAFE, 32'h0000_FFFF, 64'h0);
   endtask

   task automatic test_full_queue_stall();
      int saved;
      set_timers(4'd15, 16'd3, 16'd2);
      saved = send_idle_pct;
      send_idle_pct = 0;
      hold_left = 300;
      repeat (20) send_word(CMD_READING, 1'b1, pick32(), pick32(), {$urandom(), $urandom()});
      send_idle_pct = saved;
   endtask

   task automatic drive_random_word();
      int          r;
      cmd_type     cmd;
      logic        ok;
      logic [31:0] uid;
      logic [31:0] seq;
      logic [63:0] body;
      r    = $urandom_range(0, 99);
      uid  = pick32();
      seq  = pick32();
      body = {$urandom(), $urandom()};
      ok   = 1'b1;
      cmd  = CMD_TICK;
      if (r < 8) begin
         cmd = cmd_type'($urandom_range(0, 3));
         ok  = 1'($urandom_range(0, 1));
      end else if (relay_phase == PH_IDLE || r < 22) begin
         cmd = CMD_READING;
         ok  = ($urandom_range(0, 9) != 0);
      end else begin
         case (relay_phase)
            PH_SEND: begin
               cmd = CMD_OUTCOME;
               ok  = ($urandom_range(0, 3) != 0);
            end
            PH_LISTEN: begin
               r = $urandom_range(0, 99);
               if (r >= 40) begin
                  cmd = CMD_FRAME;
                  uid = relay_store[relay_head].uid;
                  seq = relay_store[relay_head].seq;
                  // near misses
                  if (r < 55) begin
                     case ($urandom_range(0, 2))
                        0: ok = 1'b0;
                        1: uid = uid ^ (32'd1 << $urandom_range(0, 31));
                        default: seq = seq ^ (32'd1 << $urandom_range(0, 31));
                     endcase
                  end
               end
            end
            default: cmd = CMD_TICK;
         endcase
      end
      send_word(cmd, ok, uid, seq, body);
   endtask

   task automatic test_random(int words, int send_pct, int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      repeat (words) drive_random_word();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      relay_head       = '0;
      relay_tail       = '0;
      relay_count      = '0;
      relay_phase      = PH_IDLE;
      relay_attempt    = '0;
      relay_timer      = '0;
      cfg_max_attempts = RST_MAX_ATTEMPTS;
      cfg_ack_timeout  = RST_ACK_TIMEOUT;
      cfg_backoff      = RST_BACKOFF;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 15;
      rsp_idle_pct  = 82;
      test_length_drop();
      test_ignored_when_idle();
      test_ack_path();
      test_send_failures();
      test_zero_timers();
      test_zero_attempts();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_longest_timers();
      test_full_queue_stall();

      test_random(300, 15, 82);
      set_timers(4'd15, 16'd1, 16'd0);
      test_random(300, 82, 15);
      set_timers(4'd1, 16'd4, 16'd1);
      test_random(150, 0, 0);
      set_timers(4'd3, 16'd3, 16'd2);
      test_random(150, 0, 0);
      wait_quiet();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
